@@ hw/rtl/fir_linear_convolution_core_macros.svh @@
// Assertion macros shared by the queue and back-end RTL files of the convolution core.
`ifndef FIR_LINEAR_CONVOLUTION_CORE_MACROS_SVH
`define FIR_LINEAR_CONVOLUTION_CORE_MACROS_SVH

`ifndef ASSERT_OFF

`define FLC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: check failed");

`define FLC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");

`else

`define FLC_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define FLC_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ hw/rtl/flc_pkg.sv @@
`default_nettype none

package flc_pkg;

  localparam int unsigned TapsDefault   = 16;
  localparam int unsigned MaxOut        = 16;
  localparam int unsigned QDepthDefault = 2;

  localparam int unsigned IdxW     = 4;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned ProdW    = 2 * SampleW;
  localparam int unsigned OutW     = 37;
  localparam int unsigned LenW     = 5;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 40;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                  kind;
    logic [IdxW-1:0]            idx;
    logic signed [SampleW-1:0]  value;
    logic                       last;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MAC  = 2'd1,
    ST_ACC  = 2'd2,
    ST_OUT  = 2'd3
  } back_st_e;

endpackage

`default_nettype wire

@@ hw/rtl/flc_front.sv @@
`default_nettype none

module flc_front import flc_pkg::*; #(
  parameter int unsigned MaxLen = TapsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // Bits [3:0] tap_index, [19:4] sample_in, [23:20] zero.
  input  wire logic [InDataW-1:0] s_axis_tdata_i,
  // Bit [0] func.
  input  wire logic               s_axis_tuser_i,
  input  wire logic               s_axis_tlast_i,
  output logic                    push_o,
  output cmd_t                    cmd_o,
  input  wire logic               full_i
);

  logic accept;
  logic keep;
  cmd_t dec_cmd;
  logic valid_q, valid_d;
  cmd_t cmd_q;

  always_comb begin
    dec_cmd.kind  = s_axis_tuser_i ? CMD_SAMPLE : CMD_LOAD;
    dec_cmd.idx   = s_axis_tdata_i[IdxW-1:0];
    dec_cmd.value = s_axis_tdata_i[IdxW +: SampleW];
    dec_cmd.last  = s_axis_tlast_i;
  end

  // A load aimed past the coefficient store is dropped here.
  assign keep = (dec_cmd.kind == CMD_SAMPLE) ||
                ({1'b0, dec_cmd.idx} < LenW'(MaxLen));

  assign push_o          = valid_q && !full_i;
  assign s_axis_tready_o = !valid_q || !full_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign valid_d         = (accept && keep) || (valid_q && !push_o);
  assign cmd_o           = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= dec_cmd;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/flc_queue.sv @@
`default_nettype none

`include "fir_linear_convolution_core_macros.svh"

module flc_queue import flc_pkg::*; #(
  parameter int unsigned Depth = QDepthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      head_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  `FLC_ASSERT_IMP(a_no_push_when_full, clk_i, rst_ni, full_o, !push_i)
  `FLC_ASSERT_IMP(a_no_pop_when_empty, clk_i, rst_ni, empty_o, !pop_i)
  `FLC_ASSERT_NXT(a_count_tracks_push, clk_i, rst_ni, push_i && !pop_i,
                  count_q == $past(count_q) + CntW'(1))

endmodule

`default_nettype wire

@@ hw/rtl/flc_back.sv @@
`default_nettype none

`include "fir_linear_convolution_core_macros.svh"

module flc_back import flc_pkg::*; #(
  parameter int unsigned MaxLen = TapsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [LenW-1:0]     len_i,
  input  wire cmd_t                head_i,
  input  wire logic                empty_i,
  output logic                     pop_o,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // Bits [36:0] out_sample, [39:37] zero.
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  output logic                     m_axis_tlast_o
);

  localparam int unsigned KW      = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int unsigned DlDepth = (MaxLen > 1) ? MaxLen - 1 : 1;
  localparam int unsigned DlW     = (DlDepth > 1) ? $clog2(DlDepth) : 1;

  back_st_e st_q, st_d;

  logic signed [SampleW-1:0] coef_q [MaxLen];
  logic signed [SampleW-1:0] dl_q [DlDepth];
  logic signed [SampleW-1:0] dl_d [DlDepth];

  logic [KW-1:0]             k_q, k_d;
  logic [KW-1:0]             tail_q, tail_d;
  logic                      last_q, last_d;
  logic signed [SampleW-1:0] x_q, x_d;
  logic signed [ProdW-1:0]   prod_q, prod_d;
  logic signed [OutW-1:0]    acc_q, acc_d;
  logic                      out_valid_q, out_valid_d;
  logic [OutW-1:0]           out_data_q, out_data_d;
  logic                      out_last_q, out_last_d;

  logic                      out_free;
  logic                      mac_done;
  logic                      start;
  logic                      coef_we;
  logic signed [SampleW-1:0] coef_rd;
  logic signed [SampleW-1:0] opnd;
  logic [DlW-1:0]            dl_idx;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign mac_done = (LenW'(k_q) == len_i - LenW'(1));
  assign pop_o    = (st_q == ST_IDLE) && !empty_i;
  assign start    = pop_o && (head_i.kind == CMD_SAMPLE);
  assign coef_we  = pop_o && (head_i.kind == CMD_LOAD);
  assign dl_idx   = DlW'(k_q - KW'(1));
  assign coef_rd  = coef_q[k_q];
  assign opnd     = (k_q == '0) ? x_q : dl_q[dl_idx];

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (start) begin
          st_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (mac_done) begin
          st_d = ST_ACC;
        end
      end
      ST_ACC: begin
        st_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          st_d = (last_q && (tail_q != '0)) ? ST_MAC : ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    k_d         = k_q;
    tail_d      = tail_q;
    last_d      = last_q;
    x_d         = x_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_valid_d = m_axis_tready_i ? 1'b0 : out_valid_q;
    dl_d        = dl_q;
    case (st_q)
      ST_IDLE: begin
        if (start) begin
          x_d    = head_i.value;
          last_d = head_i.last;
          tail_d = head_i.last ? KW'(len_i - LenW'(1)) : '0;
          k_d    = '0;
          acc_d  = '0;
          prod_d = '0;
        end
      end
      ST_MAC: begin
        prod_d = coef_rd * opnd;
        acc_d  = acc_q + OutW'(prod_q);
        k_d    = k_q + KW'(1);
      end
      ST_ACC: begin
        acc_d = acc_q + OutW'(prod_q);
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = acc_q;
          out_last_d  = last_q && (tail_q == '0);
          if (last_q && (tail_q == '0)) begin
            for (int i = 0; i < DlDepth; i++) begin
              dl_d[i] = '0;
            end
          end else begin
            dl_d[0] = x_q;
            for (int i = 1; i < DlDepth; i++) begin
              dl_d[i] = dl_q[i-1];
            end
          end
          if (last_q && (tail_q != '0)) begin
            x_d    = '0;
            tail_d = tail_q - KW'(1);
            k_d    = '0;
            acc_d  = '0;
            prod_d = '0;
          end
        end
      end
      default: begin
        out_valid_d = out_valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      tail_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < DlDepth; i++) begin
        dl_q[i] <= '0;
      end
    end else begin
      st_q        <= st_d;
      tail_q      <= tail_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      dl_q        <= dl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    x_q        <= x_d;
    prod_q     <= prod_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_q[KW'(head_i.idx)] <= head_i.value;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataW'(out_data_q);
  assign m_axis_tlast_o  = out_last_q;

  `FLC_ASSERT_IMP(a_tap_in_range, clk_i, rst_ni, st_q == ST_MAC, LenW'(k_q) < len_i)
  `FLC_ASSERT_IMP(a_tail_only_on_last, clk_i, rst_ni, tail_q != '0, last_q)
  `FLC_ASSERT_NXT(a_out_from_out_state, clk_i, rst_ni,
                  !out_valid_q && (st_q != ST_OUT), !out_valid_q)

endmodule

`default_nettype wire

@@ hw/rtl/fir_linear_convolution_core.sv @@
// Each sample beat gives one output, computed by the back end on its single shared
// multiply-accumulate; the back end takes no new beat from the queue until it has
// issued that output. A final sample adds kernel_len - 1 tail outputs.
// A coefficient load is taken by the back end while it is idle.
// Reset clears the delay line and sets kernel_len to 1; coefficients are undefined
// until loaded.
`default_nettype none

module fir_linear_convolution_core import flc_pkg::*; #(
  parameter int unsigned Taps       = TapsDefault,
  parameter int unsigned QueueDepth = QDepthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [LenW-1:0]     cfg_wdata_i,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // Bits [3:0] tap_index, [19:4] sample_in, [23:20] zero.
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // Bit [0] func.
  input  wire logic                s_axis_tuser_i,
  input  wire logic                s_axis_tlast_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // Bits [36:0] out_sample, [39:37] zero.
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  output logic                     m_axis_tlast_o
);

  localparam int unsigned MaxLen = (Taps < MaxOut) ? Taps : MaxOut;

  logic [LenW-1:0] klen_q;
  logic [LenW-1:0] eff_len;
  logic            push;
  cmd_t            push_cmd;
  logic            full;
  logic            pop;
  cmd_t            head;
  logic            empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q <= LenW'(1);
    end else if (cfg_we_i) begin
      klen_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (klen_q == '0) begin
      eff_len = LenW'(1);
    end else if (klen_q > LenW'(MaxLen)) begin
      eff_len = LenW'(MaxLen);
    end else begin
      eff_len = klen_q;
    end
  end

  flc_front #(
    .MaxLen (MaxLen)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .push_o          (push),
    .cmd_o           (push_cmd),
    .full_i          (full)
  );

  flc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty)
  );

  flc_back #(
    .MaxLen (MaxLen)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .len_i           (eff_len),
    .head_i          (head),
    .empty_i         (empty),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire
